// ===== hdl/cla_pkg.sv =====
`default_nettype none

package cla_pkg;

    // Lockout levels
    typedef enum logic [2:0] {
        LK_CLEAR  = 3'd0,
        LK_BLUE   = 3'd1,
        LK_GREEN  = 3'd2,
        LK_YELLOW = 3'd3,
        LK_RED    = 3'd4
    } lock_t;

    // Light colours
    typedef enum logic [2:0] {
        COL_OFF    = 3'd0,
        COL_BLUE   = 3'd1,
        COL_GREEN  = 3'd2,
        COL_YELLOW = 3'd3,
        COL_RED    = 3'd4
    } colour_t;

    // Input operations
    typedef enum logic [1:0] {
        OP_CTRL    = 2'd0,
        OP_SPECIAL = 2'd1,
        OP_SAMPLE  = 2'd2
    } op_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_REPLY     = 2'd0,
        KIND_INDICATOR = 2'd1,
        KIND_ERROR     = 2'd2
    } kind_t;

    // ASCII letters
    localparam logic [7:0] CHR_B   = 8'h42;
    localparam logic [7:0] CHR_C   = 8'h43;
    localparam logic [7:0] CHR_D   = 8'h44;
    localparam logic [7:0] CHR_G   = 8'h47;
    localparam logic [7:0] CHR_O   = 8'h4F;
    localparam logic [7:0] CHR_R   = 8'h52;
    localparam logic [7:0] CHR_S   = 8'h53;
    localparam logic [7:0] CHR_Y   = 8'h59;
    localparam logic [7:0] CHR_LB  = 8'h62;
    localparam logic [7:0] CHR_LC  = 8'h63;
    localparam logic [7:0] CHR_LG  = 8'h67;
    localparam logic [7:0] CHR_LO  = 8'h6F;
    localparam logic [7:0] CHR_LR  = 8'h72;
    localparam logic [7:0] CHR_LY  = 8'h79;
    localparam logic [7:0] CHR_NUL = 8'h00;
    localparam logic [7:0] TARGET_ALL = 8'hFF;

    localparam int unsigned MaxResults = 3;

    // One result item
    typedef struct packed {
        kind_t      kind;
        logic [7:0] code;
        logic [7:0] mode;
        logic [7:0] destination;
    } result_t;

    // All results caused by one item
    typedef struct packed {
        result_t [MaxResults-1:0] res;
        logic [1:0]               cnt;
    } batch_t;

    function automatic logic [7:0] colour_letter(input colour_t c);
        logic [7:0] l;
        begin
            case (c)
                COL_BLUE:   l = CHR_B;
                COL_GREEN:  l = CHR_G;
                COL_YELLOW: l = CHR_Y;
                COL_RED:    l = CHR_R;
                default:    l = CHR_O;
            endcase
            return l;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/cla_arbiter.sv =====
`default_nettype none

module cla_arbiter (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire logic             four_colour,
    input  wire logic [1:0]       operation,
    input  wire logic [7:0]       sender,
    input  wire logic [7:0]       command,
    input  wire logic [7:0]       clear_level,
    output cla_pkg::batch_t       batch
);

    cla_pkg::lock_t   lockout_reg, lockout_next;
    cla_pkg::colour_t requested_reg, requested_next;
    cla_pkg::colour_t shown_reg, shown_next;
    logic             blocked_reg, blocked_next;

    logic [7:0]       reply;
    logic [1:0]       n;
    cla_pkg::op_t     op;

    assign op = cla_pkg::op_t'(operation);

    // Apply priority rules and build the result list
    always_comb
    begin
        lockout_next   = lockout_reg;
        requested_next = requested_reg;
        shown_next     = shown_reg;
        blocked_next   = blocked_reg;
        reply          = cla_pkg::CHR_NUL;
        n              = 2'd0;
        for (int i = 0; i < cla_pkg::MaxResults; i++)
        begin
            batch.res[i] = '{kind: cla_pkg::KIND_REPLY, code: cla_pkg::CHR_NUL,
                             mode: cla_pkg::CHR_NUL, destination: 8'd0};
        end

        case (op)
            cla_pkg::OP_CTRL:
            begin
                unique case (command)
                    cla_pkg::CHR_B:
                    begin
                        if (lockout_reg == cla_pkg::LK_CLEAR)
                        begin
                            lockout_next   = cla_pkg::LK_BLUE;
                            requested_next = cla_pkg::COL_BLUE;
                            reply          = cla_pkg::CHR_LB;
                        end
                        else if (lockout_reg == cla_pkg::LK_BLUE)
                        begin
                            reply = cla_pkg::CHR_LB;
                        end
                    end
                    cla_pkg::CHR_G:
                    begin
                        if (lockout_reg == cla_pkg::LK_CLEAR || lockout_reg == cla_pkg::LK_BLUE
                            || lockout_reg == cla_pkg::LK_GREEN)
                        begin
                            lockout_next   = cla_pkg::LK_GREEN;
                            requested_next = cla_pkg::COL_GREEN;
                            reply          = cla_pkg::CHR_LG;
                        end
                    end
                    cla_pkg::CHR_Y:
                    begin
                        if (lockout_reg != cla_pkg::LK_RED)
                        begin
                            lockout_next   = cla_pkg::LK_YELLOW;
                            requested_next = cla_pkg::COL_YELLOW;
                            reply          = cla_pkg::CHR_LY;
                        end
                    end
                    cla_pkg::CHR_R:
                    begin
                        lockout_next   = cla_pkg::LK_RED;
                        requested_next = cla_pkg::COL_RED;
                        reply          = cla_pkg::CHR_LR;
                    end
                    cla_pkg::CHR_C:
                    begin
                        unique case (clear_level)
                            cla_pkg::CHR_B:
                            begin
                                if (lockout_reg == cla_pkg::LK_CLEAR
                                    || lockout_reg == cla_pkg::LK_BLUE)
                                begin
                                    lockout_next = cla_pkg::LK_CLEAR;
                                    reply        = cla_pkg::CHR_LC;
                                end
                            end
                            cla_pkg::CHR_Y:
                            begin
                                // Green lockout cleared as yellow drops to yellow
                                if (lockout_reg == cla_pkg::LK_GREEN)
                                begin
                                    requested_next = cla_pkg::COL_YELLOW;
                                end
                                if (lockout_reg == cla_pkg::LK_CLEAR
                                    || lockout_reg == cla_pkg::LK_GREEN
                                    || lockout_reg == cla_pkg::LK_YELLOW)
                                begin
                                    lockout_next = cla_pkg::LK_CLEAR;
                                    reply        = cla_pkg::CHR_LC;
                                end
                            end
                            cla_pkg::CHR_G:
                            begin
                                if (lockout_reg == cla_pkg::LK_CLEAR
                                    || lockout_reg == cla_pkg::LK_GREEN)
                                begin
                                    lockout_next = cla_pkg::LK_CLEAR;
                                    reply        = cla_pkg::CHR_LC;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    default:
                    begin
                    end
                endcase
            end
            cla_pkg::OP_SPECIAL:
            begin
                unique case (command)
                    cla_pkg::CHR_R:
                    begin
                        lockout_next   = cla_pkg::LK_RED;
                        requested_next = cla_pkg::COL_RED;
                        reply          = cla_pkg::CHR_LR;
                    end
                    cla_pkg::CHR_Y:
                    begin
                        lockout_next   = cla_pkg::LK_YELLOW;
                        requested_next = cla_pkg::COL_YELLOW;
                        reply          = cla_pkg::CHR_LY;
                    end
                    cla_pkg::CHR_O:
                    begin
                        lockout_next   = cla_pkg::LK_CLEAR;
                        requested_next = cla_pkg::COL_OFF;
                        reply          = cla_pkg::CHR_LO;
                    end
                    cla_pkg::CHR_C:
                    begin
                        lockout_next = cla_pkg::LK_CLEAR;
                        reply        = cla_pkg::CHR_LC;
                    end
                    default:
                    begin
                    end
                endcase
            end
            cla_pkg::OP_SAMPLE:
            begin
                // First sample after a change is swallowed
                if (!blocked_reg)
                begin
                    batch.res[0] = '{kind: cla_pkg::KIND_ERROR,
                                     code: cla_pkg::colour_letter(shown_reg),
                                     mode: cla_pkg::CHR_NUL, destination: 8'd0};
                    n = 2'd1;
                end
                else
                begin
                    blocked_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        if (op == cla_pkg::OP_CTRL || op == cla_pkg::OP_SPECIAL)
        begin
            if (reply != cla_pkg::CHR_NUL)
            begin
                batch.res[n] = '{kind: cla_pkg::KIND_REPLY, code: reply,
                                 mode: cla_pkg::CHR_NUL, destination: sender};
                n = n + 2'd1;
            end
            // Colour change: all off, then the new colour
            if (shown_reg != requested_next)
            begin
                blocked_next = 1'b1;
                shown_next   = requested_next;
                batch.res[n] = '{kind: cla_pkg::KIND_INDICATOR, code: cla_pkg::TARGET_ALL,
                                 mode: cla_pkg::CHR_O, destination: 8'd0};
                n = n + 2'd1;
                if (requested_next == cla_pkg::COL_BLUE)
                begin
                    if (four_colour)
                    begin
                        batch.res[n] = '{kind: cla_pkg::KIND_INDICATOR, code: cla_pkg::CHR_B,
                                         mode: cla_pkg::CHR_D, destination: 8'd0};
                    end
                    else
                    begin
                        batch.res[n] = '{kind: cla_pkg::KIND_INDICATOR, code: cla_pkg::CHR_G,
                                         mode: cla_pkg::CHR_S, destination: 8'd0};
                    end
                    n = n + 2'd1;
                end
                else if (requested_next != cla_pkg::COL_OFF)
                begin
                    batch.res[n] = '{kind: cla_pkg::KIND_INDICATOR,
                                     code: cla_pkg::colour_letter(requested_next),
                                     mode: cla_pkg::CHR_S, destination: 8'd0};
                    n = n + 2'd1;
                end
            end
        end
        batch.cnt = n;
    end

    // Commit state when the item moves into the result buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_reg   <= cla_pkg::LK_CLEAR;
            requested_reg <= cla_pkg::COL_OFF;
            shown_reg     <= cla_pkg::COL_OFF;
            blocked_reg   <= 1'b1;
        end
        else if (load)
        begin
            lockout_reg   <= lockout_next;
            requested_reg <= requested_next;
            shown_reg     <= shown_next;
            blocked_reg   <= blocked_next;
        end
    end

    // After any committed message the light shows what was requested
    a_shown_follows: assert property (@(posedge clk) disable iff (!rst_n)
        load && (op == cla_pkg::OP_CTRL || op == cla_pkg::OP_SPECIAL)
        |=> shown_reg == requested_reg)
        else $error("shown colour differs from requested colour after a message");

    // A colour change always re-arms the sample block
    a_block_on_change: assert property (@(posedge clk) disable iff (!rst_n)
        load && shown_next != shown_reg |=> blocked_reg)
        else $error("sample block not set after colour change");

    // Red lockout only comes with a red request
    a_red_lock: assert property (@(posedge clk) disable iff (!rst_n)
        lockout_reg == cla_pkg::LK_RED |-> requested_reg == cla_pkg::COL_RED)
        else $error("red lockout without red request");

endmodule

`default_nettype wire

// ===== hdl/cla_out_buffer.sv =====
`default_nettype none

module cla_out_buffer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire cla_pkg::batch_t  batch,
    output logic                  free,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [1:0]            kind,
    output logic [7:0]            code,
    output logic [7:0]            mode,
    output logic [7:0]            destination,
    output logic                  last
);

    cla_pkg::result_t [cla_pkg::MaxResults-1:0] res_reg;
    logic [1:0] cnt_reg;
    logic [1:0] idx_reg;
    logic       xfer;
    cla_pkg::result_t cur;

    assign out_valid = idx_reg < cnt_reg;
    assign last      = out_valid && (idx_reg + 2'd1 == cnt_reg);
    assign xfer      = out_valid && out_ready;
    // Room for a new batch once the final result transfers
    assign free      = !out_valid || (xfer && last);

    assign cur         = res_reg[idx_reg];
    assign kind        = cur.kind;
    assign code        = cur.code;
    assign mode        = cur.mode;
    assign destination = cur.destination;

    // Hold result payloads
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= batch.res;
        end
    end

    // Advance through the batch one transfer at a time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= batch.cnt;
            idx_reg <= 2'd0;
        end
        else if (xfer)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= cnt_reg)
        else $error("result index past batch count");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("batch loaded over pending results");

    a_valid_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind != 2'd3)
        else $error("invalid result kind presented");

endmodule

`default_nettype wire

// ===== hdl/colour_lockout_arbiter_top.sv =====
`default_nettype none

// Signal light colour arbiter. An accepted item is held in the input
// register until the result buffer is free, then its rules are evaluated and its
// results (up to three) are loaded into the result buffer, which presents them
// one per cycle while out_ready is high on the output port, with last marking
// the final one. Items that produce no result load an empty batch and leave
// the buffer free; otherwise a new batch loads in the cycle that the final result
// of the previous batch transfers on the single result port. The configuration write
// channel is always ready and should be used only while the block is idle.
module colour_lockout_arbiter_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       four_colour,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] operation,
    input  wire logic [7:0] sender,
    input  wire logic [7:0] command,
    input  wire logic [7:0] clear_level,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      kind,
    output logic [7:0]      code,
    output logic [7:0]      mode,
    output logic [7:0]      destination,
    output logic            last
);

    logic            four_colour_reg;
    logic            in_valid_reg;
    logic [1:0]      operation_reg;
    logic [7:0]      sender_reg;
    logic [7:0]      command_reg;
    logic [7:0]      clear_level_reg;
    logic            free;
    logic            load;
    cla_pkg::batch_t batch;

    assign cfg_ready = 1'b1;
    assign load      = in_valid_reg && free;
    assign in_ready  = !in_valid_reg || load;

    // Hold the light type
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_colour_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            four_colour_reg <= four_colour;
        end
    end

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (load)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Capture the item on transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            operation_reg   <= operation;
            sender_reg      <= sender;
            command_reg     <= command;
            clear_level_reg <= clear_level;
        end
    end

    cla_arbiter u_arbiter (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .four_colour (four_colour_reg),
        .operation   (operation_reg),
        .sender      (sender_reg),
        .command     (command_reg),
        .clear_level (clear_level_reg),
        .batch       (batch)
    );

    cla_out_buffer u_out_buffer (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .batch       (batch),
        .free        (free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .code        (code),
        .mode        (mode),
        .destination (destination),
        .last        (last)
    );

endmodule

`default_nettype wire
